// ===== rtl/bpnfa_pkg.sv =====
// shared types, constants and command codes for the bit-parallel nfa step engine
package bpnfa_pkg;

  // nfa width and alphabet size
  localparam int STATE_BITS = 64;
  localparam int ALPHABET   = 256;

  // table index widths
  localparam int POS_AW = $clog2(STATE_BITS);
  localparam int CLS_AW = $clog2(ALPHABET);

  // active-position vector
  typedef logic [STATE_BITS-1:0] vec_t;

  // request command codes
  typedef enum logic [2:0] {
    CMD_LOAD_CLASS = 3'd0,
    CMD_LOAD_FWD   = 3'd1,
    CMD_LOAD_BWD   = 3'd2,
    CMD_START      = 3'd3,
    CMD_STEP       = 3'd4
  } cmd_t;

  // one request
  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  byte_code;
    logic [5:0]  position;
    logic [63:0] row_data;
  } in_t;

  // one result
  typedef struct packed {
    logic [63:0] active_vector;
    logic        accepting;
    logic        dead;
  } out_t;

endpackage

// ===== rtl/bit_parallel_nfa_step.sv =====
// Bit-parallel NFA step engine: takes one request per clock while the result channel is not
// stalled and returns one result per request, through an input stage that also reads the
// character-class table, then a result register. The sustained rate is one request per cycle
// when out_ready holds high; what bounds the clock is the closure, a 63-row AND-OR over the
// closure table registers that feeds the active vector combinationally. The character-class
// table is a 256-entry memory with one valid bit per entry cleared at reset, so it is usable
// right after reset with no clearing pass; the closure tables are registers cleared by reset.
// The direction register is written through the cfg port, which is always ready; write it
// only while the engine is idle.
module bit_parallel_nfa_step (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_ready,
  input  bpnfa_pkg::in_t    in_data,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output bpnfa_pkg::out_t   out_data,
  // direction register write
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);

  // control and state
  logic                       direction_r;
  logic                       s1_vld_r;
  bpnfa_pkg::in_t             s1_req_r;
  bpnfa_pkg::vec_t            s1_cls_r;
  logic                       s1_cls_ok_r;
  logic                       out_vld_r;
  bpnfa_pkg::out_t            out_data_r;
  bpnfa_pkg::vec_t            active_r;
  bpnfa_pkg::vec_t            active_nxt;

  // tables
  bpnfa_pkg::vec_t            cls_mem [bpnfa_pkg::ALPHABET];
  logic [bpnfa_pkg::ALPHABET-1:0] cls_vld_r;
  bpnfa_pkg::vec_t            fwd_rows_r [bpnfa_pkg::STATE_BITS];
  bpnfa_pkg::vec_t            bwd_rows_r [bpnfa_pkg::STATE_BITS];

  // handshake and decode
  logic                       in_acc;
  logic                       s1_adv;
  logic                       in_code_ok;
  logic [bpnfa_pkg::CLS_AW-1:0] in_cls_idx;
  logic                       s1_pos_ok;
  logic [bpnfa_pkg::POS_AW-1:0] s1_pos_idx;
  bpnfa_pkg::vec_t            s1_row;
  bpnfa_pkg::vec_t            s1_cls;
  bpnfa_pkg::vec_t            clos_in;
  bpnfa_pkg::vec_t            clos_out;

  // pipeline flow: result register frees the input stage
  assign s1_adv    = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !s1_vld_r || s1_adv;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // request field decode
  assign in_code_ok = ({1'b0, in_data.byte_code} < 9'(bpnfa_pkg::ALPHABET));
  assign in_cls_idx = in_data.byte_code[bpnfa_pkg::CLS_AW-1:0];
  assign s1_pos_ok  = ({1'b0, s1_req_r.position} < 7'(bpnfa_pkg::STATE_BITS));
  assign s1_pos_idx = s1_req_r.position[bpnfa_pkg::POS_AW-1:0];
  assign s1_row     = s1_req_r.row_data[bpnfa_pkg::STATE_BITS-1:0];
  assign s1_cls     = s1_cls_ok_r ? s1_cls_r : '0;

  // direction register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      direction_r <= cfg_data;
    end
  end

  // class table: written and read at request acceptance
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cls_r <= cls_mem[in_cls_idx];
      if (in_data.cmd == bpnfa_pkg::CMD_LOAD_CLASS && in_code_ok) begin
        cls_mem[in_cls_idx] <= in_data.row_data[bpnfa_pkg::STATE_BITS-1:0];
      end
    end
  end

  // class table valid bits, and the valid bit read with the row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_vld_r   <= '0;
      s1_cls_ok_r <= 1'b0;
    end else if (in_acc) begin
      s1_cls_ok_r <= in_code_ok && cls_vld_r[in_cls_idx];
      if (in_data.cmd == bpnfa_pkg::CMD_LOAD_CLASS && in_code_ok) begin
        cls_vld_r[in_cls_idx] <= 1'b1;
      end
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r <= in_data;
    end
  end

  // closure input select
  always_comb begin
    clos_in = '0;
    if (s1_req_r.cmd == bpnfa_pkg::CMD_START) begin
      clos_in = s1_row;
    end else if (!direction_r) begin
      clos_in = (active_r & s1_cls) >> 1;
    end else begin
      clos_in = active_r;
    end
  end

  // closure: or of the rows of every set bit above the accept position
  always_comb begin
    clos_out = '0;
    for (int p = 1; p < bpnfa_pkg::STATE_BITS; p++) begin
      clos_out = clos_out | ((direction_r ? bwd_rows_r[p] : fwd_rows_r[p])
                             & {bpnfa_pkg::STATE_BITS{clos_in[p]}});
    end
  end

  // next active vector
  always_comb begin
    active_nxt = active_r;
    unique case (bpnfa_pkg::cmd_t'(s1_req_r.cmd))
      bpnfa_pkg::CMD_START: active_nxt = clos_out;
      bpnfa_pkg::CMD_STEP: begin
        if (!direction_r) begin
          active_nxt = clos_out;
        end else begin
          active_nxt = (clos_out << 1) & s1_cls;
        end
      end
      default: active_nxt = active_r;
    endcase
  end

  // closure tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < bpnfa_pkg::STATE_BITS; p++) begin
        fwd_rows_r[p] <= '0;
        bwd_rows_r[p] <= '0;
      end
    end else if (s1_adv && s1_pos_ok) begin
      if (s1_req_r.cmd == bpnfa_pkg::CMD_LOAD_FWD) begin
        fwd_rows_r[s1_pos_idx] <= s1_row;
      end
      if (s1_req_r.cmd == bpnfa_pkg::CMD_LOAD_BWD) begin
        bwd_rows_r[s1_pos_idx] <= s1_row;
      end
    end
  end

  // active vector and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        active_r <= active_nxt;
      end
      if (!out_vld_r || out_ready) begin
        out_vld_r <= s1_vld_r;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r.active_vector <= 64'(active_nxt);
      out_data_r.accepting     <= active_nxt[0];
      out_data_r.dead          <= (active_nxt == '0);
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/bpnfa_chk.sv =====
// port-level checker for the nfa step engine, bound to the top level
module bpnfa_chk (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input bpnfa_pkg::in_t  in_data,
  input logic            out_valid,
  input logic            out_ready,
  input bpnfa_pkg::out_t out_data,
  input logic            cfg_valid,
  input logic            cfg_ready,
  input logic            cfg_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // accept flag follows bit 0 of the vector
  a_accepting: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.accepting == out_data.active_vector[0])
    else $error("accepting flag disagrees with vector");

  // dead flag follows an empty vector
  a_dead: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.dead == (out_data.active_vector == 64'd0))
    else $error("dead flag disagrees with vector");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // bits beyond the nfa width stay clear
  a_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.active_vector >> bpnfa_pkg::STATE_BITS) == 64'd0)
    else $error("vector bit set beyond nfa width");

endmodule

bind bit_parallel_nfa_step bpnfa_chk u_bpnfa_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_data  (cfg_data)
);
